@@ hw/rtl/counting_bloom_filter_defines.svh @@
// assertion helpers used by cbf_back
`ifndef COUNTING_BLOOM_FILTER_DEFINES_SVH
`define COUNTING_BLOOM_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define CBF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("counting bloom filter check failed");
`define CBF_ASSERT_IMPL(lbl, ante, cons) \
    `CBF_ASSERT(lbl, (ante) |-> (cons))
`else
`define CBF_ASSERT(lbl, prop)
`define CBF_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/cbf_pkg.sv @@
package cbf_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_HASHES  = 8;

    localparam int IDX_W        = 10;
    localparam int NUM_IDX      = 8;
    localparam int IDXSEL_W     = $clog2(NUM_IDX);
    localparam int IDX_FIELDS_W = IDX_W * NUM_IDX;
    localparam int OP_W         = 2;
    localparam int CNT_W        = 32;
    localparam int NH_W         = 4;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DW       = 4;
    localparam int STATUS_W     = 2;
    localparam int OUT_DW       = 8;
    localparam int QUEUE_DEPTH  = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    // counter width modes
    localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_16 = 2'd1;

    localparam logic [CNT_W-1:0] MASK_8  = 32'h0000_00FF;
    localparam logic [CNT_W-1:0] MASK_16 = 32'h0000_FFFF;
    localparam logic [CNT_W-1:0] MASK_32 = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_MODE = 1'b1;

    localparam logic [NH_W-1:0]   DEF_NUM_HASHES   = 4'd4;
    localparam logic [MODE_W-1:0] DEF_COUNTER_MODE = 2'd2;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_REMOVE,
        KIND_TEST
    } kind_t;

    typedef struct packed {
        kind_t                             kind;
        logic [NUM_IDX-1:0][IDX_W-1:0]     idx;
    } cmd_t;

    typedef struct packed {
        logic [NH_W-1:0]   num_hashes;
        logic [MODE_W-1:0] counter_mode;
    } cfg_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

@@ hw/rtl/cbf_front.sv @@
module cbf_front
    import cbf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IDX_FIELDS_W-1:0] s_tdata,   // index_0 .. index_7, 10 bits each
    input  logic [OP_W-1:0]         s_tuser,   // operation
    input  back_stat_t              stat,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output cmd_t                    cmd
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [QPW-1:0]    wr_ptr_reg;
    logic [QPW-1:0]    rd_ptr_reg;
    logic [QCW-1:0]    count_reg;
    cmd_t              new_cmd;
    logic              push;
    logic              pop;

    // op three acts as a test
    always_comb
    begin
        new_cmd.idx = s_tdata;
        unique case (s_tuser)
            OP_ADD:    new_cmd.kind = KIND_ADD;
            OP_REMOVE: new_cmd.kind = KIND_REMOVE;
            default:   new_cmd.kind = KIND_TEST;
        endcase
    end

    assign s_tready  = !stat.clearing && (count_reg != QCW'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = queue_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/cbf_back.sv @@
`include "counting_bloom_filter_defines.svh"

module cbf_back
    import cbf_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_HASHES  = DEF_MAX_HASHES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output back_stat_t        stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata    // status, hit, zero fill
);

    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int KW          = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int RECIP_SHIFT = 21;
    localparam int RW          = 21;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + TABLE_DEPTH - 1) / TABLE_DEPTH;
    localparam int PROD_W      = IDX_W + RW;
    localparam int PW          = IDX_W + $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUO,
        S_ADDR,
        S_TCHK,
        S_UADDR,
        S_UCHK,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [KW-1:0]         k_reg;
    logic                  hit_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic                  m_tvalid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_hit_reg;

    cmd_t                  cmd_reg;
    logic [IDX_W-1:0]      q_reg;
    logic [AW-1:0]         slot_reg;
    logic [AW-1:0]         slots_reg [MAX_HASHES];
    logic [CNT_W-1:0]      rdata_reg;
    logic [CNT_W-1:0]      counter_mem [TABLE_DEPTH];

    logic [NH_W-1:0]       n_eff;
    logic [KW-1:0]         n_last;
    logic [CNT_W-1:0]      mask;
    logic [IDX_W-1:0]      cur_idx;
    logic [PROD_W-1:0]     prod;
    logic [IDX_W-1:0]      q_next;
    logic [PW-1:0]         rem;
    logic [AW-1:0]         slot_next;
    logic [AW-1:0]         slot_cur;
    logic [CNT_W-1:0]      vmasked;
    logic [CNT_W-1:0]      inc_val;
    logic [CNT_W-1:0]      dec_val;
    logic                  hit_now;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [CNT_W-1:0]      mem_wdata;

    // zero hashes means one, too many means the most this build holds
    always_comb
    begin
        if (cfg.num_hashes == '0)
        begin
            n_eff = NH_W'(1);
        end
        else if (cfg.num_hashes > NH_W'(MAX_HASHES))
        begin
            n_eff = NH_W'(MAX_HASHES);
        end
        else
        begin
            n_eff = cfg.num_hashes;
        end
    end

    assign n_last = KW'(n_eff - NH_W'(1));

    always_comb
    begin
        case (cfg.counter_mode)
            MODE_8:  mask = MASK_8;
            MODE_16: mask = MASK_16;
            default: mask = MASK_32;
        endcase
    end

    // bucket reduction: reciprocal quotient into q_reg, then the remainder from q_reg
    assign cur_idx   = cmd_reg.idx[IDXSEL_W'(k_reg)];
    assign prod      = PROD_W'(cur_idx) * PROD_W'(RECIP);
    assign q_next    = prod[RECIP_SHIFT +: IDX_W];
    assign rem       = PW'(cur_idx) - PW'(q_reg) * PW'(TABLE_DEPTH);
    assign slot_next = rem[AW-1:0];
    assign slot_cur  = slots_reg[k_reg];

    assign vmasked = rdata_reg & mask;
    assign inc_val = (vmasked == mask) ? vmasked : vmasked + 1'b1;
    assign dec_val = vmasked - 1'b1;
    assign hit_now = hit_reg && (vmasked != '0);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = slot_reg;
        mem_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            S_ADDR:
            begin
                mem_addr = slot_next;
            end
            S_UADDR:
            begin
                mem_addr = slot_cur;
            end
            S_UCHK:
            begin
                mem_we    = (cmd_reg.kind == KIND_ADD) ||
                            ((cmd_reg.kind == KIND_REMOVE) && (vmasked != '0));
                mem_wdata = (cmd_reg.kind == KIND_ADD) ? inc_val : dec_val;
            end
            default:
            begin
                mem_addr = slot_reg;
            end
        endcase
    end

    // single port counter table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            counter_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= counter_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_QUO)
        begin
            q_reg <= q_next;
        end
        if (state_reg == S_ADDR)
        begin
            slot_reg         <= slot_next;
            slots_reg[k_reg] <= slot_next;
        end
        if (state_reg == S_UADDR)
        begin
            slot_reg <= slot_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            k_reg          <= '0;
            hit_reg        <= 1'b0;
            status_reg     <= STATUS_OK;
            clr_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_hit_reg    <= 1'b0;
        end
        else
        begin
            // in S_DONE a new result takes over the register being drained
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(TABLE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        k_reg      <= '0;
                        hit_reg    <= 1'b1;
                        status_reg <= STATUS_OK;
                        state_reg  <= S_QUO;
                    end
                end
                S_QUO:
                begin
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    state_reg <= S_TCHK;
                end
                S_TCHK:
                begin
                    // test pass always walks every index so the slots are all known
                    hit_reg <= hit_now;
                    if (k_reg != n_last)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_QUO;
                    end
                    else
                    begin
                        k_reg <= '0;
                        case (cmd_reg.kind)
                            KIND_ADD:
                            begin
                                state_reg <= S_UADDR;
                            end
                            KIND_REMOVE:
                            begin
                                if (hit_now)
                                begin
                                    state_reg <= S_UADDR;
                                end
                                else
                                begin
                                    status_reg <= STATUS_ABSENT;
                                    state_reg  <= S_DONE;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_UADDR:
                begin
                    state_reg <= S_UCHK;
                end
                S_UCHK:
                begin
                    // a repeated index can drain a counter mid remove
                    if (cmd_reg.kind == KIND_REMOVE && vmasked == '0)
                    begin
                        status_reg <= STATUS_UNDERFLOW;
                        state_reg  <= S_DONE;
                    end
                    else if (k_reg == n_last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_UADDR;
                    end
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= status_reg;
                        out_hit_reg    <= hit_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_ready      = (state_reg == S_IDLE);
    assign stat.clearing  = (state_reg == S_CLEAR);
    assign m_tvalid       = m_tvalid_reg;
    assign m_tdata        = {(OUT_DW - STATUS_W - 1)'(0), out_hit_reg, out_status_reg};

    `CBF_ASSERT(a_result_after_done, $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
    `CBF_ASSERT_IMPL(a_underflow_has_hit, m_tvalid_reg && out_status_reg == STATUS_UNDERFLOW, out_hit_reg)
    `CBF_ASSERT_IMPL(a_absent_is_miss, m_tvalid_reg && out_status_reg == STATUS_ABSENT, !out_hit_reg)
    `CBF_ASSERT_IMPL(a_error_only_remove, state_reg == S_DONE && status_reg != STATUS_OK, cmd_reg.kind == KIND_REMOVE)

endmodule

@@ hw/rtl/counting_bloom_filter.sv @@
// after reset the counter table is cleared one entry a cycle, every entry, no item taken
// for each used hash the back end takes a quotient step, an address step that reads the
// single-port table and a check step; add and a remove hit then update each index with an
// address step and a write step; m_tvalid rises from S_DONE, later while m_tready holds it off
// the two-entry queue and the output register let input and output stall on their own
// configuration registers reset to four hashes and 32-bit counters
module counting_bloom_filter
    import cbf_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_HASHES  = DEF_MAX_HASHES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IDX_FIELDS_W-1:0] s_tdata,    // index_0 .. index_7, 10 bits each
    input  logic [OP_W-1:0]         s_tuser,    // operation
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DW-1:0]       m_tdata,    // status [1:0], hit [2], zero fill
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]       cfg_wdata
);

    logic [NH_W-1:0]   num_hashes_reg;
    logic [MODE_W-1:0] counter_mode_reg;
    cfg_t              cfg;
    back_stat_t        stat;
    logic              cmd_valid;
    logic              cmd_ready;
    cmd_t              cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg   <= DEF_NUM_HASHES;
            counter_mode_reg <= DEF_COUNTER_MODE;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_NUM_HASHES)
            begin
                num_hashes_reg <= cfg_wdata[NH_W-1:0];
            end
            else if (cfg_index == REG_COUNTER_MODE)
            begin
                counter_mode_reg <= cfg_wdata[MODE_W-1:0];
            end
        end
    end

    assign cfg.num_hashes   = num_hashes_reg;
    assign cfg.counter_mode = counter_mode_reg;

    cbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .stat      (stat),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    cbf_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_HASHES  (MAX_HASHES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import cbf_pkg::*;

    // unused operation code, the block treats it as a membership test
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 60;

    typedef logic [NUM_IDX-1:0][IDX_W-1:0] bucket_set_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                hit;
    } verdict_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IDX_FIELDS_W-1:0] s_tdata;   // index_0 .. index_7, 10 bits each
    logic [OP_W-1:0]         s_tuser;   // operation
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DW-1:0]       m_tdata;   // status [1:0], hit [2], zero fill
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DW-1:0]       cfg_wdata;

    // predicted counter table and register copies
    logic [CNT_W-1:0]  bucket_counts [DEF_TABLE_DEPTH];
    logic [NH_W-1:0]   cur_hashes;
    logic [MODE_W-1:0] cur_mode;

    verdict_t    pending_verdicts [$];
    bucket_set_t key_pool [$];
    verdict_t    want;

    int tx_idle_pct;
    int rx_idle_pct;
    int errors;
    int results_seen;
    int cycle_count;
    int n_add;
    int n_remove;
    int n_test;
    int n_absent;
    int n_underflow;
    int n_hit;

    counting_bloom_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_verdicts.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected item, actual tdata=%h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                results_seen++;
                if (m_tdata[1:0] !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d", $time,
                             want.status, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[2] !== want.hit)
                begin
                    $display("%0t: hit mismatch, expected %0d actual %0d", $time,
                             want.hit, m_tdata[2]);
                    errors++;
                end
            end
        end
    end

    // applies one operation to the predicted table, sequential per index so
    // repeated indices see earlier updates
    task automatic bloom_apply(input logic [OP_W-1:0] op, input bucket_set_t b,
                               output verdict_t v);
        logic [CNT_W-1:0] mask;
        logic [CNT_W-1:0] val;
        int n;
        int slot;
        logic stop;
        mask = (cur_mode == MODE_8) ? MASK_8 : (cur_mode == MODE_16) ? MASK_16 : MASK_32;
        n = int'(cur_hashes);
        if (n == 0)
            n = 1;
        if (n > DEF_MAX_HASHES)
            n = DEF_MAX_HASHES;
        v.status = STATUS_OK;
        v.hit = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            if ((bucket_counts[b[k] % DEF_TABLE_DEPTH] & mask) == '0)
                v.hit = 1'b0;
        end
        if (op == OP_ADD)
        begin
            for (int k = 0; k < n; k++)
            begin
                slot = b[k] % DEF_TABLE_DEPTH;
                val = bucket_counts[slot] & mask;
                if (val != mask)
                    val++;
                bucket_counts[slot] = val;
            end
        end
        else if (op == OP_REMOVE)
        begin
            if (!v.hit)
                v.status = STATUS_ABSENT;
            else
            begin
                stop = 1'b0;
                for (int k = 0; k < n; k++)
                begin
                    slot = b[k] % DEF_TABLE_DEPTH;
                    val = bucket_counts[slot] & mask;
                    if (!stop)
                    begin
                        if (val == '0)
                        begin
                            v.status = STATUS_UNDERFLOW;
                            stop = 1'b1;
                        end
                        else
                            bucket_counts[slot] = val - 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input bucket_set_t b);
        verdict_t v;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bloom_apply(op, b, v);
        pending_verdicts.push_back(v);
        if (op == OP_ADD)
            n_add++;
        else if (op == OP_REMOVE)
            n_remove++;
        else
            n_test++;
        if (v.status == STATUS_ABSENT)
            n_absent++;
        if (v.status == STATUS_UNDERFLOW)
            n_underflow++;
        if (v.hit)
            n_hit++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_NUM_HASHES)
            cur_hashes = val[NH_W-1:0];
        else
            cur_mode = val[MODE_W-1:0];
    endtask

    function automatic bucket_set_t fill_set(input int base, input int stride);
        bucket_set_t s;
        for (int k = 0; k < NUM_IDX; k++)
            s[k] = IDX_W'((base + k * stride) % DEF_TABLE_DEPTH);
        return s;
    endfunction

    function automatic bucket_set_t rand_set(input int span);
        bucket_set_t s;
        for (int k = 0; k < NUM_IDX; k++)
            s[k] = IDX_W'($urandom_range(span));
        return s;
    endfunction

    // defaults after reset: four hashes, 32-bit counters
    task automatic test_basic_ops();
        bucket_set_t a;
        a = fill_set(100, 7);
        send_item(OP_TEST, a);
        send_item(OP_REMOVE, a);
        send_item(OP_ADD, a);
        send_item(OP_TEST, a);
        send_item(OP_SPARE, a);
        send_item(OP_ADD, a);
        send_item(OP_REMOVE, a);
        send_item(OP_REMOVE, a);
        send_item(OP_REMOVE, a);
        send_item(OP_ADD, '1);
        send_item(OP_TEST, '1);
        send_item(OP_ADD, '0);
        send_item(OP_REMOVE, '0);
    endtask

    // zero and above-max hash counts clamp to 1 and 8
    task automatic test_hash_counts();
        bucket_set_t b;
        bucket_set_t c;
        b = fill_set(200, 1);
        c = fill_set(200, 3);
        write_reg(REG_NUM_HASHES, 4'd1);
        send_item(OP_ADD, b);
        send_item(OP_TEST, c);
        write_reg(REG_NUM_HASHES, 4'd0);
        send_item(OP_TEST, c);
        write_reg(REG_NUM_HASHES, 4'd8);
        send_item(OP_TEST, c);
        send_item(OP_ADD, c);
        write_reg(REG_NUM_HASHES, 4'd15);
        send_item(OP_TEST, c);
        c[7] = c[7] + 1'b1;
        send_item(OP_TEST, c);
    endtask

    // one bucket repeated eight times saturates an 8-bit counter in 32 adds,
    // then width changes reinterpret the held count
    task automatic test_saturation();
        bucket_set_t s;
        s = fill_set(500, 0);
        write_reg(REG_COUNTER_MODE, CFG_DW'(MODE_8));
        write_reg(REG_NUM_HASHES, 4'd8);
        repeat (33)
            send_item(OP_ADD, s);
        send_item(OP_TEST, s);
        write_reg(REG_COUNTER_MODE, CFG_DW'(MODE_16));
        send_item(OP_ADD, s);
        write_reg(REG_COUNTER_MODE, CFG_DW'(MODE_8));
        send_item(OP_TEST, s);
        send_item(OP_REMOVE, s);
        write_reg(REG_COUNTER_MODE, 4'd3);
        send_item(OP_TEST, s);
        send_item(OP_REMOVE, s);
    endtask

    // a repeated index on remove can drain a counter mid-item
    task automatic test_underflow();
        bucket_set_t u;
        bucket_set_t r;
        u = fill_set(600, 1);
        r = u;
        r[1] = r[0];
        write_reg(REG_COUNTER_MODE, 4'd2);
        write_reg(REG_NUM_HASHES, 4'd2);
        send_item(OP_ADD, u);
        send_item(OP_REMOVE, r);
        send_item(OP_TEST, u);
        send_item(OP_REMOVE, u);
        send_item(OP_ADD, u);
        send_item(OP_ADD, u);
        send_item(OP_REMOVE, r);
        send_item(OP_TEST, u);
    endtask

    // mostly add / test / remove of keys that were added, plus random noise
    task automatic run_random(input int count);
        bucket_set_t b;
        int r;
        int j;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if ($urandom_range(199) == 0)
                drain();
            if (r < 10)
                send_item(OP_W'($urandom_range(3)), rand_set(DEF_TABLE_DEPTH - 1));
            else if (key_pool.size() == 0 || r < 50)
            begin
                if (key_pool.size() == 0 || $urandom_range(9) < 7)
                begin
                    // narrow spans give shared and repeated buckets
                    b = ($urandom_range(3) == 0) ? rand_set(15) : rand_set(DEF_TABLE_DEPTH - 1);
                    if (key_pool.size() >= 48)
                        void'(key_pool.pop_front());
                    key_pool.push_back(b);
                end
                else
                    b = key_pool[$urandom_range(key_pool.size() - 1)];
                send_item(OP_ADD, b);
            end
            else if (r < 75)
            begin
                j = $urandom_range(key_pool.size() - 1);
                send_item(OP_REMOVE, key_pool[j]);
                if ($urandom_range(1) == 0)
                    key_pool.delete(j);
            end
            else
                send_item(($urandom_range(3) == 0) ? OP_SPARE : OP_TEST,
                          key_pool[$urandom_range(key_pool.size() - 1)]);
        end
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int seg = 0; seg < 4; seg++)
        begin
            write_reg(REG_NUM_HASHES, CFG_DW'($urandom_range(15)));
            write_reg(REG_COUNTER_MODE, CFG_DW'($urandom_range(3)));
            run_random(92);
        end
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_ADD;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_NUM_HASHES;
        cfg_wdata = '0;
        errors = 0;
        results_seen = 0;
        cycle_count = 0;
        n_add = 0;
        n_remove = 0;
        n_test = 0;
        n_absent = 0;
        n_underflow = 0;
        n_hit = 0;
        tx_idle_pct = 29;
        rx_idle_pct = 51;
        cur_hashes = DEF_NUM_HASHES;
        cur_mode = DEF_COUNTER_MODE;
        for (int i = 0; i < DEF_TABLE_DEPTH; i++)
            bucket_counts[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_hash_counts();
        test_saturation();
        test_underflow();
        test_random_phase(29, 51);
        test_random_phase(51, 29);
        test_random_phase(0, 0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d adds, %0d removes, %0d tests; %0d results checked",
                 n_add, n_remove, n_test, results_seen);
        $display("hits %0d, absent removes %0d, underflows %0d, mismatches %0d",
                 n_hit, n_absent, n_underflow, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
